FILE: rtl/lru_buffer_pool_frame_manager_top_defines.svh
// ----------------------------------------------------------------------------
// LRU buffer pool frame manager: assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LRU_BUFFER_POOL_FRAME_MANAGER_TOP_DEFINES_SVH
`define LRU_BUFFER_POOL_FRAME_MANAGER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LRUBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrubp: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define LRUBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrubp: next-cycle check failed");

`endif

FILE: rtl/lrubp_pkg.sv
// ----------------------------------------------------------------------------
// lrubp_pkg
// Sizes, opcodes, state encoding and cell structures of the frame manager.
// ----------------------------------------------------------------------------
package lrubp_pkg;

    localparam int NUM_FRAMES    = 8;
    localparam int BLOCK_ID_BITS = 24;
    localparam int FRAME_BITS    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int COUNT_BITS    = $clog2(NUM_FRAMES + 1);

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_ACCESS,
        ST_FLUSH
    } state_t;

    // one recency slot: which frame sits here and what it holds
    typedef struct packed
    {
        logic                     valid;
        logic                     dirty;
        logic [FRAME_BITS-1:0]    frame;
        logic [BLOCK_ID_BITS-1:0] tag;
    } entry_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed
    {
        logic                     update;
        logic                     flush_clr;
        logic [FRAME_BITS-1:0]    clr_frame;
        logic [BLOCK_ID_BITS-1:0] blk;
    } cell_ctrl_t;

endpackage

FILE: rtl/lru_buffer_pool_frame_manager_top.sv
// ----------------------------------------------------------------------------
// LRU buffer pool frame manager
// Access: accept, then tag match and recency shift;
// the result strobes in the cycle after the match, when busy is low again.
// Flush: accept, then one transfer per dirty frame; an empty flush
// gives one result. The recency chain shifts once per access.
// Reset clears all valid and dirty bits, the fill count and the sequencer.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module lru_buffer_pool_frame_manager_top
    import lrubp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // command side
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               op,
    input  logic [BLOCK_ID_BITS-1:0] block_num,
    // result side, one transfer per done strobe
    output logic                     done,
    output logic                     hit,
    output logic [FRAME_BITS-1:0]    frame_index,
    output logic                     fill_needed,
    output logic                     writeback,
    output logic [BLOCK_ID_BITS-1:0] writeback_block,
    output logic                     last
);

`include "lru_buffer_pool_frame_manager_top_defines.svh"

    // ------------------------------------------------------------------
    // Request capture and sequencer state
    // ------------------------------------------------------------------
    state_t                   state_reg, state_next;
    logic [1:0]               op_reg, op_next;
    logic [BLOCK_ID_BITS-1:0] blk_reg, blk_next;
    // frames are taken in ascending order and never released, so the
    // lowest free frame is simply the count of frames handed out so far
    logic [COUNT_BITS-1:0]    alloc_count_reg, alloc_count_next;

    // registered result transfer
    logic                     done_reg, done_next;
    logic                     hit_reg, hit_next;
    logic [FRAME_BITS-1:0]    frame_reg, frame_next;
    logic                     fill_reg, fill_next;
    logic                     wb_reg, wb_next;
    logic [BLOCK_ID_BITS-1:0] wbblk_reg, wbblk_next;
    logic                     last_reg, last_next;

    // ------------------------------------------------------------------
    // Recency chain
    // ------------------------------------------------------------------
    cell_ctrl_t            ctrl;
    entry_t                head;
    entry_t                entries [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] hits;
    logic                  any_hit;

    lrubp_chain u_chain
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .head    (head),
        .entries (entries),
        .hits    (hits),
        .any_hit (any_hit)
    );

    // ------------------------------------------------------------------
    // Access datapath: the hit slot is one-hot since resident tags are unique
    // ------------------------------------------------------------------
    entry_t hit_entry;
    entry_t victim;
    logic   full;
    logic   is_write;

    always_comb
    begin
        hit_entry = '0;
        for (int k = 0; k < NUM_FRAMES; k++)
        begin
            if (hits[k])
            begin
                hit_entry = hit_entry | entries[k];
            end
        end
    end

    // valid slots are packed from the MRU end, so the last slot being
    // valid means every frame is in use and that slot is the LRU victim
    assign victim   = entries[NUM_FRAMES-1];
    assign full     = victim.valid;
    assign is_write = (op_reg == OP_WRITE);

    always_comb
    begin
        head.valid = 1'b1;
        head.tag   = blk_reg;
        if (any_hit)
        begin
            head.frame = hit_entry.frame;
            head.dirty = hit_entry.dirty | is_write;
        end
        else
        begin
            head.frame = full ? victim.frame : alloc_count_reg[FRAME_BITS-1:0];
            head.dirty = is_write;
        end
    end

    // ------------------------------------------------------------------
    // Flush datapath: dirty frames by frame number, lowest first
    // ------------------------------------------------------------------
    logic [NUM_FRAMES-1:0]    dirty_mask;
    logic [NUM_FRAMES-1:0]    flush_sel;
    logic [FRAME_BITS-1:0]    flush_frame;
    logic [BLOCK_ID_BITS-1:0] flush_tag;
    logic                     flush_more;

    always_comb
    begin
        dirty_mask = '0;
        for (int f = 0; f < NUM_FRAMES; f++)
        begin
            for (int k = 0; k < NUM_FRAMES; k++)
            begin
                if (entries[k].valid && entries[k].dirty
                    && (entries[k].frame == FRAME_BITS'(f)))
                begin
                    dirty_mask[f] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        flush_sel   = '0;
        flush_frame = '0;
        for (int f = NUM_FRAMES - 1; f >= 0; f--)
        begin
            if (dirty_mask[f])
            begin
                flush_sel   = '0;
                flush_sel[f] = 1'b1;
                flush_frame = FRAME_BITS'(f);
            end
        end
    end

    always_comb
    begin
        flush_tag = '0;
        for (int k = 0; k < NUM_FRAMES; k++)
        begin
            if (entries[k].valid && entries[k].dirty && (entries[k].frame == flush_frame))
            begin
                flush_tag = flush_tag | entries[k].tag;
            end
        end
    end

    assign flush_more = |(dirty_mask & ~flush_sel);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        blk_next         = blk_reg;
        alloc_count_next = alloc_count_reg;

        done_next  = 1'b0;
        hit_next   = hit_reg;
        frame_next = frame_reg;
        fill_next  = fill_reg;
        wb_next    = wb_reg;
        wbblk_next = wbblk_reg;
        last_next  = last_reg;

        ctrl.update    = 1'b0;
        ctrl.flush_clr = 1'b0;
        ctrl.clr_frame = flush_frame;
        ctrl.blk       = blk_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next  = op;
                    blk_next = block_num;
                    case (op)
                        OP_READ, OP_WRITE: state_next = ST_ACCESS;
                        OP_FLUSH:          state_next = ST_FLUSH;
                        default:           state_next = ST_IDLE;   // unused code, dropped
                    endcase
                end
            end

            ST_ACCESS:
            begin
                ctrl.update = 1'b1;
                done_next   = 1'b1;
                hit_next    = any_hit;
                frame_next  = head.frame;
                fill_next   = !any_hit;
                wb_next     = !any_hit && full && victim.dirty;
                wbblk_next  = (!any_hit && full && victim.dirty) ? victim.tag : '0;
                last_next   = 1'b1;
                if (!any_hit && !full)
                begin
                    alloc_count_next = alloc_count_reg + COUNT_BITS'(1);
                end
                state_next = ST_IDLE;
            end

            ST_FLUSH:
            begin
                done_next = 1'b1;
                hit_next  = 1'b0;
                fill_next = 1'b0;
                if (|dirty_mask)
                begin
                    ctrl.flush_clr = 1'b1;
                    frame_next     = flush_frame;
                    wb_next        = 1'b1;
                    wbblk_next     = flush_tag;
                    last_next      = !flush_more;
                    state_next     = flush_more ? ST_FLUSH : ST_IDLE;
                end
                else
                begin
                    // nothing dirty: a single empty transfer closes the flush
                    frame_next = '0;
                    wb_next    = 1'b0;
                    wbblk_next = '0;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            alloc_count_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            alloc_count_reg <= alloc_count_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        blk_reg   <= blk_next;
        hit_reg   <= hit_next;
        frame_reg <= frame_next;
        fill_reg  <= fill_next;
        wb_reg    <= wb_next;
        wbblk_reg <= wbblk_next;
        last_reg  <= last_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign hit             = hit_reg;
    assign frame_index     = frame_reg;
    assign fill_needed     = fill_reg;
    assign writeback       = wb_reg;
    assign writeback_block = wbblk_reg;
    assign last            = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic access_accept;

    assign access_accept = start && !busy && ((op == OP_READ) || (op == OP_WRITE));

    // an accepted read or write always leads to the match cycle
    `LRUBP_ASSERT_NEXT(a_access_enters, access_accept, state_reg == ST_ACCESS)
    // the match cycle always produces exactly one final transfer
    `LRUBP_ASSERT_NEXT(a_access_result, state_reg == ST_ACCESS, done && last)
    // a hit never asks for a fill or a writeback
    `LRUBP_ASSERT_NOW(a_hit_clean, done && hit, !fill_needed && !writeback)
    // frames handed out never exceed the pool
    `LRUBP_ASSERT_NOW(a_count_bound, 1'b1, alloc_count_reg <= COUNT_BITS'(NUM_FRAMES))

endmodule

FILE: rtl/lrubp_cell.sv
// ----------------------------------------------------------------------------
// lrubp_cell
// One recency slot: tag compare, shift-in from the more recent neighbor,
// dirty clear on flush.
// ----------------------------------------------------------------------------
module lrubp_cell
    import lrubp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       found_in,
    input  entry_t     prev,
    output logic       found_out,
    output logic       hit,
    output entry_t     entry
);

    logic                     valid_reg, valid_next;
    logic                     dirty_reg, dirty_next;
    logic [FRAME_BITS-1:0]    frame_reg, frame_next;
    logic [BLOCK_ID_BITS-1:0] tag_reg, tag_next;
    logic                     take;

    assign hit       = valid_reg && (tag_reg == ctrl.blk);
    assign found_out = found_in | hit;
    // slots up to and including the hit slot move one step toward LRU
    assign take      = ctrl.update && !found_in;

    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        frame_next = frame_reg;
        tag_next   = tag_reg;
        if (take)
        begin
            valid_next = prev.valid;
            dirty_next = prev.dirty;
            frame_next = prev.frame;
            tag_next   = prev.tag;
        end
        else if (ctrl.flush_clr && (frame_reg == ctrl.clr_frame))
        begin
            dirty_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        tag_reg   <= tag_next;
    end

    assign entry.valid = valid_reg;
    assign entry.dirty = dirty_reg;
    assign entry.frame = frame_reg;
    assign entry.tag   = tag_reg;

endmodule

FILE: rtl/lrubp_chain.sv
// ----------------------------------------------------------------------------
// lrubp_chain
// Row of recency cells, MRU at slot 0, LRU at the last slot.
// ----------------------------------------------------------------------------
module lrubp_chain
    import lrubp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  entry_t                head,
    output entry_t                entries [NUM_FRAMES],
    output logic [NUM_FRAMES-1:0] hits,
    output logic                  any_hit
);

    logic [NUM_FRAMES-1:0] found;

    for (genvar k = 0; k < NUM_FRAMES; k++)
    begin : g_cell
        entry_t prev_k;
        logic   found_in_k;

        if (k == 0)
        begin : g_head
            assign prev_k     = head;
            assign found_in_k = 1'b0;
        end
        else
        begin : g_body
            assign prev_k     = entries[k-1];
            assign found_in_k = found[k-1];
        end

        lrubp_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .found_in  (found_in_k),
            .prev      (prev_k),
            .found_out (found[k]),
            .hit       (hits[k]),
            .entry     (entries[k])
        );
    end

    assign any_hit = found[NUM_FRAMES-1];

endmodule
